// ===== rtl/rms_pkg.sv =====
// ----------------------------------------------------------------------------
// rms_pkg
// Shared types and constants of the radio message segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package rms_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 13;
  // Data slots per packet never exceed 30, so five bits hold every count.
  localparam int CHUNK_W   = 5;
  localparam int HEADER_BYTES = 2;

  // One command per accepted message byte, from the front end to the back end.
  typedef struct packed {
    logic [BYTE_W-1:0]  data;     // message byte
    logic               hdr;      // a packet starts with this byte
    logic [BYTE_W-1:0]  pkts;     // packets still to follow
    logic [CHUNK_W-1:0] n;        // data bytes in this packet
    logic [CHUNK_W-1:0] pad;      // zero bytes after the data byte
    logic               eop;      // final emitted byte closes a packet
    logic               eom;      // final emitted byte closes the message
  } cmd_t;

  typedef enum logic [3:0] {
    PH_CNT  = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_DATA = 4'b0100,
    PH_PAD  = 4'b1000
  } phase_t;

endpackage

`default_nettype wire

// ===== rtl/rms_front.sv =====
// ----------------------------------------------------------------------------
// rms_front
// Accepts message bytes, computes the packet count and tracks the message
// state; issues one command per message byte that belongs to a message.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_front
  import rms_pkg::*;
#(
  parameter int PACKET_BYTES      = 32,
  parameter int MAX_MESSAGE_BYTES = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_data,
  input  wire logic              in_first,
  input  wire logic [LEN_W-1:0]  in_len,
  input  wire logic              q_full,
  output logic                   q_push,
  output cmd_t                   q_cmd
);

  localparam int DS     = PACKET_BYTES - HEADER_BYTES;
  localparam int NUM_W  = LEN_W + 1;
  localparam int SH     = NUM_W + CHUNK_W;
  localparam int RECIP  = ((2 ** SH) + DS - 1) / DS;
  localparam int PROD_W = NUM_W + SH;

  localparam logic [LEN_W-1:0]   MAX_LEN = LEN_W'(MAX_MESSAGE_BYTES);
  localparam logic [CHUNK_W-1:0] DS_C    = CHUNK_W'(DS);

  // Stage A: saturated length and packet count.
  logic                a_valid_r;
  logic [BYTE_W-1:0]   a_data_r;
  logic                a_first_r;
  logic [LEN_W-1:0]    a_len_r;
  logic [BYTE_W-1:0]   a_pcount_r;

  logic [LEN_W-1:0]    len_sat;
  logic [NUM_W-1:0]    num;
  logic [PROD_W-1:0]   prod;
  logic                a_adv;

  assign len_sat = (in_len > MAX_LEN) ? MAX_LEN : in_len;
  assign num     = NUM_W'(len_sat) + NUM_W'(DS - 1);
  // Exact ceiling division by the slot count through a reciprocal multiply.
  assign prod    = PROD_W'(num) * PROD_W'(RECIP);

  assign a_adv    = a_valid_r && !q_full;
  assign in_ready = !a_valid_r || a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_data_r   <= in_data;
      a_first_r  <= in_first;
      a_len_r    <= len_sat;
      a_pcount_r <= prod[SH+BYTE_W-1:SH];
    end
  end

  // Stage B: message state update and command issue.
  logic               active_r, active_nxt;
  logic [LEN_W-1:0]   br_r, br_nxt;
  logic [BYTE_W-1:0]  pr_r, pr_nxt;
  logic [CHUNK_W-1:0] cl_r, cl_nxt;
  logic               issue;

  always_comb begin
    active_nxt = active_r;
    br_nxt     = br_r;
    pr_nxt     = pr_r;
    cl_nxt     = cl_r;
    issue      = 1'b0;
    q_cmd      = '0;
    q_cmd.data = a_data_r;
    if (a_first_r) begin
      if (a_len_r == '0) begin
        active_nxt = 1'b0;
        br_nxt     = '0;
        pr_nxt     = '0;
      end else begin
        active_nxt = 1'b1;
        br_nxt     = a_len_r;
        pr_nxt     = a_pcount_r;
      end
      cl_nxt = '0;
    end
    if (active_nxt) begin
      issue = 1'b1;
      if (cl_nxt == '0) begin
        pr_nxt      = pr_nxt - 1'b1;
        q_cmd.hdr   = 1'b1;
        q_cmd.pkts  = pr_nxt;
        q_cmd.n     = (br_nxt < LEN_W'(DS)) ? br_nxt[CHUNK_W-1:0] : DS_C;
        cl_nxt      = DS_C;
      end
      cl_nxt = cl_nxt - 1'b1;
      br_nxt = br_nxt - 1'b1;
      if (br_nxt == '0) begin
        // Last message byte: pad the packet out to its full size.
        q_cmd.pad  = cl_nxt;
        q_cmd.eop  = 1'b1;
        q_cmd.eom  = 1'b1;
        cl_nxt     = '0;
        active_nxt = 1'b0;
        pr_nxt     = '0;
      end else begin
        q_cmd.eop = (cl_nxt == '0);
      end
    end
  end

  assign q_push = a_adv && issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      br_r     <= '0;
      pr_r     <= '0;
      cl_r     <= '0;
    end else if (a_adv) begin
      active_r <= active_nxt;
      br_r     <= br_nxt;
      pr_r     <= pr_nxt;
      cl_r     <= cl_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rms_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// rms_cmd_fifo
// Four-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_cmd_fifo
  import rms_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  cmd_t               mem_r [DEPTH];
  logic [PTR_W-1:0]   wp_r, rp_r;
  logic [PTR_W:0]     cnt_r;
  logic               do_push, do_pop;

  assign full       = (cnt_r == (PTR_W+1)'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rms_back.sv =====
// ----------------------------------------------------------------------------
// rms_back
// Expands each command into packet bytes: header, data byte and padding, one
// byte per cycle into a registered output stage unless the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_back
  import rms_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cmd_valid,
  input  wire cmd_t               cmd,
  output logic                    cmd_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [BYTE_W-1:0]       out_byte,
  output logic                    out_eop,
  output logic                    out_eom
);

  phase_t             phase_r, phase_nxt, ph;
  logic [CHUNK_W-1:0] pcnt_r, pcnt_nxt;
  logic               emit, last;
  logic [BYTE_W-1:0]  byte_c;

  logic               ov_r;
  logic [BYTE_W-1:0]  ob_r;
  logic               oeop_r, oeom_r;

  assign emit = cmd_valid && (!ov_r || out_ready);
  // A command without a header starts straight at its data byte.
  assign ph   = (phase_r == PH_CNT && !cmd.hdr) ? PH_DATA : phase_r;

  always_comb begin
    phase_nxt = phase_r;
    pcnt_nxt  = pcnt_r;
    byte_c    = '0;
    last      = 1'b0;
    unique case (ph)
      PH_CNT: begin
        byte_c    = cmd.pkts;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        byte_c    = BYTE_W'(cmd.n);
        phase_nxt = PH_DATA;
      end
      PH_DATA: begin
        byte_c    = cmd.data;
        last      = (cmd.pad == '0);
        phase_nxt = last ? PH_CNT : PH_PAD;
        pcnt_nxt  = '0;
      end
      PH_PAD: begin
        byte_c    = '0;
        last      = (pcnt_r + 1'b1 == cmd.pad);
        phase_nxt = last ? PH_CNT : PH_PAD;
        pcnt_nxt  = pcnt_r + 1'b1;
      end
      default: begin
        phase_nxt = PH_CNT;
      end
    endcase
  end

  assign cmd_pop = emit && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CNT;
      pcnt_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (emit) begin
        phase_r <= phase_nxt;
        pcnt_r  <= pcnt_nxt;
      end
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ob_r   <= byte_c;
      oeop_r <= last && cmd.eop;
      oeom_r <= last && cmd.eom;
    end
  end

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_eop   = oeop_r;
  assign out_eom   = oeom_r;

endmodule

`default_nettype wire

// ===== rtl/radio_message_segmenter_unit.sv =====
// ----------------------------------------------------------------------------
// radio_message_segmenter_unit
// Cuts a byte stream into fixed-size radio packets with a two-byte header
// (packets still to follow, data byte count) and zero padding at the end.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                          | tlast          | tuser
//  in_     | slave     | [7:0] data_byte,               | -              | first
//          |           | [20:8] message_length          |                |
//  out_    | master    | [7:0] out_byte                 | end_of_packet  | end_of_message
//
//  An accepted byte is registered in the front end, then its command waits in
//  a four-entry queue. The back end sends one packet byte per cycle while the
//  output is not stalled, so a message byte makes 1 to PACKET_BYTES packet bytes
//  (header, data, padding); the output port sets the sustained rate within a
//  message. Reset is synchronous and empties every stage.
//  A stalled output fills the queue and then holds in_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module radio_message_segmenter_unit
  import rms_pkg::*;
#(
  parameter int PACKET_BYTES      = 32,
  parameter int MAX_MESSAGE_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] data_byte, [20:8] message_length
  input  wire logic        in_tuser,   // first
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tlast,  // end_of_packet
  output logic             out_tuser   // end_of_message
);

  logic q_full, q_push, q_pop, q_valid;
  cmd_t q_in, q_head;

  rms_front #(
    .PACKET_BYTES      (PACKET_BYTES),
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata[BYTE_W-1:0]),
    .in_first (in_tuser),
    .in_len   (in_tdata[BYTE_W+LEN_W-1:BYTE_W]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_in)
  );

  rms_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  rms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_eop   (out_tlast),
    .out_eom   (out_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/rms_checker.sv =====
// ----------------------------------------------------------------------------
// rms_checker
// Port-level checks of the segmenter's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast,
  input wire logic       out_tuser
);

  // The end of a message always closes a packet.
  a_eom_is_eop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("end of message without end of packet");

  // Nothing is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind radio_message_segmenter_unit rms_checker u_rms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== verif/radio_message_segmenter_unit_test.sv =====
// ----------------------------------------------------------------------------
// radio_message_segmenter_unit_test
// Self-checking bench for the radio message segmenter. A short scripted run
// covers idle bytes, zero and oversized lengths and restarts mid-message.
// Random messages follow, some of them cut short, under changing input gaps
// and output stalls. Every packet byte is checked against a predictor.
// ----------------------------------------------------------------------------
module radio_message_segmenter_unit_test
  import rms_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PACKET_BYTES      = 32;
  localparam int MAX_MESSAGE_BYTES = 4096;
  localparam int DATA_SLOTS        = PACKET_BYTES - HEADER_BYTES;
  localparam int RANDOM_ITEMS      = 115;
  localparam int RX_HOLD_CYCLES    = 300;
  localparam int SCRIPT_LEN        = 15;

  typedef enum logic {
    CHK_SILENT,   // nothing may come out of this request
    CHK_PREDICT   // results come from the predictor
  } row_check_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              first;
    logic [LEN_W-1:0]  len;
    row_check_t        chk;
  } script_row_t;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              eop;
    logic              eom;
  } pkt_byte_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  // Predictor state of the segmenter.
  bit                 seg_open       = 1'b0;
  logic [LEN_W-1:0]   seg_bytes_left = '0;
  logic [7:0]         seg_pkts_left  = '0;
  logic [CHUNK_W-1:0] seg_slots_left = '0;

  pkt_byte_t bytes_due[$];
  int        err_count    = 0;
  int        items_fed    = 0;
  int        src_idle_pct = 0;
  int        rx_stall_pct = 0;
  bit        rx_hold_req  = 1'b0;
  bit        rx_hold_on   = 1'b0;

  script_row_t script [SCRIPT_LEN] = '{
    '{8'hFF, 1'b0, 13'd0,    CHK_SILENT},   // byte with no message open
    '{8'hA5, 1'b1, 13'd0,    CHK_SILENT},   // zero length opens nothing
    '{8'h5A, 1'b0, 13'h1FFF, CHK_SILENT},   // still idle, length is not read
    '{8'h00, 1'b1, 13'd1,    CHK_PREDICT},  // one-byte message, padded out
    '{8'hFF, 1'b1, 13'd1,    CHK_PREDICT},
    '{8'h12, 1'b1, 13'd3,    CHK_PREDICT},
    '{8'h34, 1'b0, 13'd0,    CHK_PREDICT},
    '{8'hC3, 1'b1, 13'h1FFF, CHK_PREDICT},  // restart mid-message, length saturates
    '{8'h01, 1'b0, 13'd5,    CHK_PREDICT},
    '{8'h02, 1'b0, 13'd0,    CHK_PREDICT},
    '{8'h77, 1'b1, 13'd4097, CHK_PREDICT},  // restart just above the maximum
    '{8'h66, 1'b1, 13'd0,    CHK_SILENT},   // zero length drops the open message
    '{8'h99, 1'b0, 13'd2,    CHK_SILENT},
    '{8'h55, 1'b1, 13'd2,    CHK_PREDICT},
    '{8'hAA, 1'b0, 13'd0,    CHK_PREDICT}
  };

  radio_message_segmenter_unit #(
    .PACKET_BYTES      (PACKET_BYTES),
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic void due_push(input bit keep, input logic [7:0] b,
                                   input logic eop, input logic eom);
    if (keep) begin
      bytes_due.push_back('{b, eop, eom});
    end
  endfunction

  // Packet bytes that one accepted message byte completes.
  task automatic segment_byte(input logic [7:0] d, input logic f, input logic [12:0] l,
                              input bit keep, output bit used);
    int n_len;
    int chunk;
    used = 1'b0;
    if (f) begin
      n_len = (l > MAX_MESSAGE_BYTES) ? MAX_MESSAGE_BYTES : int'(l);
      if (n_len == 0) begin
        seg_open       = 1'b0;
        seg_bytes_left = '0;
        seg_pkts_left  = '0;
        seg_slots_left = '0;
        return;
      end
      seg_open       = 1'b1;
      seg_bytes_left = LEN_W'(n_len);
      seg_pkts_left  = 8'((n_len + DATA_SLOTS - 1) / DATA_SLOTS);
      seg_slots_left = '0;
    end
    if (!seg_open) begin
      return;
    end
    used = 1'b1;
    if (seg_slots_left == 0) begin
      chunk = (seg_bytes_left < DATA_SLOTS) ? int'(seg_bytes_left) : DATA_SLOTS;
      seg_pkts_left = seg_pkts_left - 8'd1;
      due_push(keep, seg_pkts_left, 1'b0, 1'b0);
      due_push(keep, 8'(chunk), 1'b0, 1'b0);
      seg_slots_left = CHUNK_W'(DATA_SLOTS);
    end
    seg_slots_left = seg_slots_left - 1'b1;
    seg_bytes_left = seg_bytes_left - 1'b1;
    if (seg_bytes_left == 0) begin
      if (seg_slots_left == 0) begin
        due_push(keep, d, 1'b1, 1'b1);
      end else begin
        due_push(keep, d, 1'b0, 1'b0);
        while (seg_slots_left > 1) begin
          due_push(keep, 8'h00, 1'b0, 1'b0);
          seg_slots_left = seg_slots_left - 1'b1;
        end
        due_push(keep, 8'h00, 1'b1, 1'b1);
      end
      seg_slots_left = '0;
      seg_open       = 1'b0;
      seg_pkts_left  = '0;
    end else begin
      due_push(keep, d, seg_slots_left == 0, 1'b0);
    end
  endtask

  task automatic send_item(input logic [7:0] d, input logic f, input logic [12:0] l,
                           input bit keep);
    bit used;
    if ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, l, d};
    in_tuser  <= f;
    do @(posedge clk); while (in_tready !== 1'b1);
    segment_byte(d, f, l, keep, used);
    if (used) begin
      items_fed++;
    end
  endtask

  // Sends the first n_bytes of a message; fewer than msg_len leaves it open.
  task automatic send_message(input int msg_len, input int n_bytes);
    int i;
    for (i = 0; i < n_bytes; i++) begin
      send_item(8'($urandom), i == 0, (i == 0) ? 13'(msg_len) : 13'($urandom), 1'b1);
    end
  endtask

  initial begin : stimulus
    int  row;
    int  pick;
    int  msg_len;
    int  n_bytes;
    bit  hold_done;
    hold_done = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row = 0; row < SCRIPT_LEN; row++) begin
      send_item(script[row].data, script[row].first, script[row].len,
                script[row].chk == CHK_PREDICT);
    end

    items_fed = 0;
    while (items_fed < RANDOM_ITEMS) begin
      if (items_fed < 45) begin
        src_idle_pct = 0;
        rx_stall_pct = 0;
      end else if (items_fed < 70) begin
        src_idle_pct = 66;
        rx_stall_pct = 0;
      end else if (items_fed < 95) begin
        src_idle_pct = 0;
        rx_stall_pct = 66;
      end else begin
        src_idle_pct = 25;
        rx_stall_pct = 25;
      end

      if (!hold_done && items_fed >= 12) begin
        // The output holds off while a two-packet message streams in.
        hold_done   = 1'b1;
        rx_hold_req = 1'b1;
        send_message(31, 31);
      end else begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          // Stray byte: ignored when idle, plain data if a message was left open.
          send_item(8'($urandom), 1'b0, 13'($urandom), 1'b1);
        end else begin
          pick = $urandom_range(99);
          if (pick < 40) begin
            msg_len = $urandom_range(1, 8);
          end else if (pick < 55) begin
            msg_len = $urandom_range(9, 31);
          end else if (pick < 70) begin
            case ($urandom_range(3))
              0: msg_len = 29;
              1: msg_len = 30;
              2: msg_len = 31;
              default: msg_len = 60;
            endcase
          end else if (pick < 80) begin
            msg_len = $urandom_range(32, 64);
          end else if (pick < 88) begin
            msg_len = $urandom_range(MAX_MESSAGE_BYTES + 1, 8191);
          end else begin
            msg_len = 0;
          end
          n_bytes = (msg_len == 0) ? 1 : msg_len;
          if (msg_len > 64 || $urandom_range(99) < 12) begin
            n_bytes = $urandom_range(1, (n_bytes > 40) ? 40 : n_bytes);
          end
          send_message(msg_len, n_bytes);
        end
      end
    end
    in_tvalid <= 1'b0;

    while (bytes_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (PACKET_BYTES + 8) @(posedge clk);
    if (err_count == 0) begin
      $display("radio_message_segmenter_unit verification clean");
    end else begin
      $display("radio_message_segmenter_unit verification failed");
    end
    $finish;
  end

  initial begin : rx_hold
    wait (rx_hold_req);
    @(posedge clk);
    rx_hold_on <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold_on <= 1'b0;
  end

  always @(posedge clk) begin : rx_check
    pkt_byte_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (bytes_due.size() == 0) begin
        $error("unexpected packet byte %02h", out_tdata);
        err_count++;
      end else begin
        want = bytes_due.pop_front();
        if (out_tdata !== want.b) begin
          $error("out_byte: expected %02h, got %02h", want.b, out_tdata);
          err_count++;
        end
        if (out_tlast !== want.eop) begin
          $error("end_of_packet: expected %0b, got %0b", want.eop, out_tlast);
          err_count++;
        end
        if (out_tuser !== want.eom) begin
          $error("end_of_message: expected %0b, got %0b", want.eom, out_tuser);
          err_count++;
        end
      end
    end
    out_tready <= !rx_hold_on && ($urandom_range(99) >= rx_stall_pct);
  end

  initial begin : watchdog
    #3_000_000;
    $display("radio_message_segmenter_unit verification failed");
    $finish;
  end

endmodule
